// ----- hw/rtl/rcpw_pkg.sv -----
package rcpw_pkg;

	// Default sizing
	localparam int NUM_CHANNELS_DEF = 6;
	localparam int TIMER_BITS_DEF   = 16;
	localparam int JOB_DEPTH_DEF    = 4;
	localparam int RES_DEPTH_DEF    = 4;

	// Field widths fixed by the interface
	localparam int CH_W    = 3;
	localparam int TIME_W  = 16;
	localparam int REG_W   = 16;
	localparam int DUTY_W  = 16;
	localparam int WID_W   = 18;	// signed pulse width incl. reload correction
	localparam int PROD_W  = 32;

	// Special channels
	localparam logic [CH_W-1:0] RIGHT_CH = 3'd0;
	localparam logic [CH_W-1:0] LEFT_CH  = 3'd3;
	localparam logic [CH_W-1:0] MODE_CH  = 3'd4;

	// Register reset values
	localparam logic [REG_W-1:0] RELOAD_RST     = 16'd50000;
	localparam logic [REG_W-1:0] DUTY_SCALE_RST = 16'd54000;
	localparam logic [REG_W-1:0] THRESHOLD_RST  = 16'd1500;

	// Duty = floor(product / 2000): shift by 4, then divide by 125 through a
	// reciprocal. Exact for products below the saturation limit.
	localparam int DUTY_DIVISOR = 2000;
	localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'((2 ** DUTY_W) * DUTY_DIVISOR);
	localparam int PRE_SHIFT   = 4;
	localparam int QUOT_IN_W   = 23;
	localparam int RECIP_W     = 24;
	localparam int RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] RECIP_M = 24'd8589935;	// ceil(2^30 / 125)
	localparam int RECIP_PROD_W = QUOT_IN_W + RECIP_W;

	// Register indexes
	typedef enum logic [1:0] {
		CFG_RELOAD     = 2'd0,
		CFG_DUTY_SCALE = 2'd1,
		CFG_THRESHOLD  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		TGT_NONE  = 2'd0,
		TGT_RIGHT = 2'd1,
		TGT_LEFT  = 2'd2
	} duty_tgt_t;

	typedef enum logic [1:0] {
		IND_KEEP = 2'd0,
		IND_LOW  = 2'd1,
		IND_HIGH = 2'd2
	} ind_drive_t;

	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic              rising;
		logic [TIME_W-1:0] timer_value;
	} in_item_t;

	typedef struct packed {
		duty_tgt_t         duty_target;
		logic [DUTY_W-1:0] duty_value;
		logic              remote_mode;
		ind_drive_t        indicator_drive;
	} out_item_t;

	// Classified event handed from front to back; width is zero when no duty
	// update is due or the measured width is not positive.
	typedef struct packed {
		duty_tgt_t         target;
		logic [DUTY_W-1:0] width;
		logic              remote_mode;
		ind_drive_t        ind;
	} job_t;

endpackage

// ----- hw/rtl/rcpw_fifo.sv -----
module rcpw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/rcpw_front.sv -----
module rcpw_front #(
	parameter int NUM_CHANNELS = rcpw_pkg::NUM_CHANNELS_DEF,
	parameter int TIMER_BITS   = rcpw_pkg::TIMER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  rcpw_pkg::in_item_t           capture,
	input  logic [rcpw_pkg::REG_W-1:0]   reload_val,
	input  logic [rcpw_pkg::REG_W-1:0]   mode_threshold,
	output rcpw_pkg::job_t               job
);

	// Timer values are only ever held modulo 2^TIMER_BITS
	localparam int NOW_W = (TIMER_BITS < rcpw_pkg::TIME_W) ? TIMER_BITS : rcpw_pkg::TIME_W;
	localparam int EXT_W = rcpw_pkg::WID_W - NOW_W - 1;
	localparam logic signed [rcpw_pkg::WID_W-1:0] WID_ZERO = '0;

	logic [NOW_W-1:0]                stamp_q [NUM_CHANNELS];
	logic                            mode_q;
	logic [NOW_W-1:0]                now;
	logic [NOW_W-1:0]                stamp_sel;
	logic                            in_range;
	logic signed [NOW_W:0]           diff;
	logic signed [rcpw_pkg::WID_W-1:0] wid_raw, wid;
	logic                            mode_next;
	logic                            is_mode_fall;

	assign now = capture.timer_value[NOW_W-1:0];

	// Stamp lookup for the addressed channel
	always_comb begin
		stamp_sel = '0;
		in_range  = 1'b0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (32'(capture.channel) == i) begin
				stamp_sel = stamp_q[i];
				in_range  = 1'b1;
			end
		end
	end

	// Pulse width; a non-positive difference wraps by the reload
	always_comb begin
		diff    = $signed({1'b0, now}) - $signed({1'b0, stamp_sel});
		wid_raw = {{EXT_W{diff[NOW_W]}}, diff};
		if (wid_raw <= WID_ZERO) begin
			wid = wid_raw + $signed({2'b00, reload_val});
		end else begin
			wid = wid_raw;
		end
	end

	assign is_mode_fall = in_range && !capture.rising && (capture.channel == rcpw_pkg::MODE_CH);
	assign mode_next    = is_mode_fall ? (wid >= $signed({2'b00, mode_threshold})) : mode_q;

	// Classification
	always_comb begin
		job             = '0;
		job.target      = rcpw_pkg::TGT_NONE;
		job.ind         = rcpw_pkg::IND_KEEP;
		job.remote_mode = mode_next;
		if (in_range) begin
			if (capture.rising) begin
				if (capture.channel == rcpw_pkg::MODE_CH) begin
					job.ind = rcpw_pkg::IND_HIGH;
				end
			end else if (capture.channel == rcpw_pkg::MODE_CH) begin
				job.ind = rcpw_pkg::IND_LOW;
			end else if (mode_q && (capture.channel == rcpw_pkg::RIGHT_CH ||
					capture.channel == rcpw_pkg::LEFT_CH)) begin
				job.target = (capture.channel == rcpw_pkg::RIGHT_CH) ?
					rcpw_pkg::TGT_RIGHT : rcpw_pkg::TGT_LEFT;
				job.width  = (wid > WID_ZERO) ? wid[rcpw_pkg::DUTY_W-1:0] : '0;
			end
		end
	end

	// Rise stamps and mode flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				stamp_q[i] <= '0;
			end
			mode_q <= 1'b0;
		end else if (take) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (capture.rising && 32'(capture.channel) == i) begin
					stamp_q[i] <= now;
				end
			end
			mode_q <= mode_next;
		end
	end

endmodule

// ----- hw/rtl/rcpw_back.sv -----
module rcpw_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rcpw_pkg::REG_W-1:0] duty_scale,
	input  rcpw_pkg::job_t             job,
	input  logic                       job_empty,
	output logic                       job_pop,
	input  logic                       res_full,
	output logic                       res_push,
	output rcpw_pkg::out_item_t        res
);

	logic                                 v_s1, v_s2;
	rcpw_pkg::job_t                       job_s1, job_s2;
	logic [rcpw_pkg::PROD_W-1:0]          prod_s1;
	logic                                 sat_s2;
	logic [rcpw_pkg::RECIP_PROD_W-1:0]    recip_s2;
	logic                                 adv;

	// Whole pipeline holds when the last stage cannot drain
	assign adv      = !(v_s2 && res_full);
	assign job_pop  = adv && !job_empty;
	assign res_push = v_s2 && !res_full;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !job_empty;
			v_s2 <= v_s1;
		end
	end

	// s1: scale by duty_scale; s2: saturation check and divide by 2000
	always_ff @(posedge clk) begin
		if (adv) begin
			job_s1   <= job;
			prod_s1  <= rcpw_pkg::PROD_W'(duty_scale) * rcpw_pkg::PROD_W'(job.width);
			job_s2   <= job_s1;
			sat_s2   <= (prod_s1 >= rcpw_pkg::SAT_LIMIT);
			recip_s2 <= rcpw_pkg::RECIP_PROD_W'(
					prod_s1[rcpw_pkg::PRE_SHIFT +: rcpw_pkg::QUOT_IN_W]) *
				rcpw_pkg::RECIP_PROD_W'(rcpw_pkg::RECIP_M);
		end
	end

	// Result assembly
	always_comb begin
		res.duty_target     = job_s2.target;
		res.duty_value      = sat_s2 ? '1 :
			recip_s2[rcpw_pkg::RECIP_SHIFT +: rcpw_pkg::DUTY_W];
		res.remote_mode     = job_s2.remote_mode;
		res.indicator_drive = job_s2.ind;
	end

endmodule

// ----- hw/rtl/rc_pulse_width_to_motor_duty.sv -----
// RC pulse-width decoder feeding two motor duty compares.
// Path: an event passes through the event queue, the multiply stage, the
// reciprocal-divide stage and the result queue, in that order.
// Throughput: one event per cycle while neither queue is full; the front classifies in the accept cycle.
// Reset: rise stamps and mode clear, registers take their defaults, queues
// empty; no clearing pass, events are taken right after reset.
module rc_pulse_width_to_motor_duty #(
	parameter int NUM_CHANNELS = rcpw_pkg::NUM_CHANNELS_DEF,
	parameter int TIMER_BITS   = rcpw_pkg::TIMER_BITS_DEF,
	parameter int JOB_DEPTH    = rcpw_pkg::JOB_DEPTH_DEF,
	parameter int RES_DEPTH    = rcpw_pkg::RES_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  rcpw_pkg::in_item_t         capture,
	output logic                       empty,
	input  logic                       pop,
	output rcpw_pkg::out_item_t        result,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [rcpw_pkg::REG_W-1:0] cfg_wdata
);

	logic [rcpw_pkg::REG_W-1:0] reload_q, duty_scale_q, threshold_q;
	logic                       take;
	rcpw_pkg::job_t             job_in, job_out;
	logic [$bits(rcpw_pkg::job_t)-1:0]      job_vec;
	logic [$bits(rcpw_pkg::out_item_t)-1:0] res_vec;
	logic                       job_empty, job_pop;
	logic                       res_full, res_push;
	rcpw_pkg::out_item_t        res_in;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q     <= rcpw_pkg::RELOAD_RST;
			duty_scale_q <= rcpw_pkg::DUTY_SCALE_RST;
			threshold_q  <= rcpw_pkg::THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (rcpw_pkg::cfg_idx_t'(cfg_index))
				rcpw_pkg::CFG_RELOAD:     reload_q     <= cfg_wdata;
				rcpw_pkg::CFG_DUTY_SCALE: duty_scale_q <= cfg_wdata;
				rcpw_pkg::CFG_THRESHOLD:  threshold_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign take = push && !full;

	rcpw_front #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.TIMER_BITS   (TIMER_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.capture        (capture),
		.reload_val     (reload_q),
		.mode_threshold (threshold_q),
		.job            (job_in)
	);

	// Queue between classification and duty computation
	rcpw_fifo #(
		.WIDTH ($bits(rcpw_pkg::job_t)),
		.DEPTH (JOB_DEPTH)
	) u_job_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take),
		.wr_data (job_in),
		.rd_en   (job_pop),
		.rd_data (job_vec),
		.full    (full),
		.empty   (job_empty)
	);

	assign job_out = rcpw_pkg::job_t'(job_vec);

	rcpw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.duty_scale (duty_scale_q),
		.job        (job_out),
		.job_empty  (job_empty),
		.job_pop    (job_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res_in)
	);

	// Result queue
	rcpw_fifo #(
		.WIDTH ($bits(rcpw_pkg::out_item_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (res_vec),
		.full    (res_full),
		.empty   (empty)
	);

	assign result = rcpw_pkg::out_item_t'(res_vec);

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rcpw_pkg::*;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                push      = 1'b0;
	logic                full;
	in_item_t            capture   = '0;
	logic                empty;
	logic                pop       = 1'b0;
	out_item_t           result;
	logic                cfg_we    = 1'b0;
	logic [1:0]          cfg_index = CFG_RELOAD;
	logic [REG_W-1:0]    cfg_wdata = '0;

	// Edge events waiting to be driven, motor updates waiting to be seen
	in_item_t            pending_edges[$];
	out_item_t           expected_updates[$];

	// Local copy of the decoder state and registers
	logic [TIME_W-1:0]   rise_time[NUM_CHANNELS_DEF];
	bit                  remote_on;
	logic [REG_W-1:0]    reload_cfg    = RELOAD_RST;
	logic [REG_W-1:0]    duty_scale_cfg = DUTY_SCALE_RST;
	logic [REG_W-1:0]    threshold_cfg = THRESHOLD_RST;

	int                  mismatches = 0;
	bit                  quiet = 1'b0;
	int                  push_gap = 0;
	int                  pop_gap = 0;

	rc_pulse_width_to_motor_duty dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.capture   (capture),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	initial begin
		foreach (rise_time[i])
			rise_time[i] = '0;
		remote_on = 1'b0;
	end

	// Decode one edge event into the expected motor update
	function automatic out_item_t decode_edge(in_item_t ev);
		out_item_t o;
		int        span;
		longint    scaled;
		o.duty_target     = TGT_NONE;
		o.duty_value      = '0;
		o.indicator_drive = IND_KEEP;
		if (ev.channel < NUM_CHANNELS_DEF) begin
			if (ev.rising) begin
				rise_time[ev.channel] = ev.timer_value;
				if (ev.channel == MODE_CH)
					o.indicator_drive = IND_HIGH;
			end else begin
				// non-positive difference means the timer wrapped: add one period
				span = int'(ev.timer_value) - int'(rise_time[ev.channel]);
				if (span <= 0)
					span += int'(reload_cfg);
				if (ev.channel == MODE_CH) begin
					o.indicator_drive = IND_LOW;
					remote_on = (span >= int'(threshold_cfg));
				end else if ((ev.channel == RIGHT_CH || ev.channel == LEFT_CH) && remote_on) begin
					o.duty_target = (ev.channel == RIGHT_CH) ? TGT_RIGHT : TGT_LEFT;
					// still negative width gives zero duty
					if (span > 0) begin
						scaled = longint'(duty_scale_cfg) * span / DUTY_DIVISOR;
						o.duty_value = (scaled > 65535) ? 16'hFFFF : scaled[15:0];
					end
				end
			end
		end
		o.remote_mode = remote_on;
		return o;
	endfunction

	function automatic int draw_gap();
		return quiet ? 0 : $urandom_range(0, 5);
	endfunction

	// Driver: one capture transaction per accepted push
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			push_gap = 0;
		end else begin
			if (push && !full)
				expected_updates.push_back(decode_edge(capture));
			if (!push || !full) begin
				if (push_gap > 0) begin
					push_gap--;
					push <= 1'b0;
				end else if (pending_edges.size() > 0) begin
					capture <= pending_edges.pop_front();
					push <= 1'b1;
					push_gap = draw_gap();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each popped transaction with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_updates.size() == 0) begin
					$display("%0t: unexpected result, got %p", $time, result);
					mismatches++;
				end else begin
					want = expected_updates.pop_front();
					if (result.duty_target !== want.duty_target) begin
						$display("%0t: duty_target expected %0d got %0d",
							$time, want.duty_target, result.duty_target);
						mismatches++;
					end
					if (result.duty_value !== want.duty_value) begin
						$display("%0t: duty_value expected %0d got %0d",
							$time, want.duty_value, result.duty_value);
						mismatches++;
					end
					if (result.remote_mode !== want.remote_mode) begin
						$display("%0t: remote_mode expected %0b got %0b",
							$time, want.remote_mode, result.remote_mode);
						mismatches++;
					end
					if (result.indicator_drive !== want.indicator_drive) begin
						$display("%0t: indicator_drive expected %0d got %0d",
							$time, want.indicator_drive, result.indicator_drive);
						mismatches++;
					end
				end
				pop_gap = draw_gap();
			end
			if (pop_gap > 0) begin
				pop_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic add_edge(logic [CH_W-1:0] ch, logic up, logic [TIME_W-1:0] t);
		in_item_t ev;
		ev.channel     = ch;
		ev.rising      = up;
		ev.timer_value = t;
		pending_edges.push_back(ev);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [REG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_RELOAD:     reload_cfg = val;
			CFG_DUTY_SCALE: duty_scale_cfg = val;
			CFG_THRESHOLD:  threshold_cfg = val;
			default: ;
		endcase
	endtask

	task automatic configure(logic [REG_W-1:0] reload, logic [REG_W-1:0] scale,
		logic [REG_W-1:0] thresh);
		write_reg(CFG_RELOAD, reload);
		write_reg(CFG_DUTY_SCALE, scale);
		write_reg(CFG_THRESHOLD, thresh);
	endtask

	// Block is idle once everything queued has been sent and answered
	task automatic settle();
		while (pending_edges.size() != 0 || push || expected_updates.size() != 0)
			@(posedge clk);
	endtask

	// Mostly rise/fall pulses on the motor and mode channels, some noise
	task automatic add_random_edges(int n);
		int                count;
		int                sel;
		int                pick;
		logic [CH_W-1:0]   ch;
		logic [TIME_W-1:0] base;
		logic [TIME_W-1:0] pw;
		count = 0;
		while (count < n) begin
			if ($urandom_range(0, 99) < 15) begin
				add_edge(CH_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
					TIME_W'($urandom_range(0, 65535)));
				count++;
			end else begin
				sel = $urandom_range(0, 9);
				if (sel < 3)
					ch = RIGHT_CH;
				else if (sel < 6)
					ch = LEFT_CH;
				else if (sel < 8)
					ch = MODE_CH;
				else if (sel == 8) begin
					pick = $urandom_range(0, 2);
					ch = (pick == 0) ? 3'd1 : (pick == 1) ? 3'd2 : 3'd5;
				end else
					ch = CH_W'($urandom_range(6, 7));
				pick = $urandom_range(0, 19);
				if (pick < 12)
					pw = TIME_W'($urandom_range(900, 2100));
				else if (pick < 14)
					pw = '0;
				else if (pick < 16)
					pw = TIME_W'($urandom_range(1, 16));
				else
					pw = TIME_W'($urandom_range(0, 65535));
				base = TIME_W'($urandom_range(0, 65535));
				add_edge(ch, 1'b1, base);
				add_edge(ch, 1'b0, base + pw);
				count += 2;
			end
		end
	endtask

	// Stimulus
	initial begin
		int phase;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// manual mode: motor channel falling edge gives no update
		add_edge(RIGHT_CH, 1'b0, 16'd1000);
		// mode pulse one below threshold, then exactly at it
		add_edge(MODE_CH, 1'b1, 16'd0);
		add_edge(MODE_CH, 1'b0, 16'd1499);
		add_edge(MODE_CH, 1'b1, 16'd100);
		add_edge(MODE_CH, 1'b0, 16'd1600);
		// plain right motor pulse
		add_edge(RIGHT_CH, 1'b1, 16'd1000);
		add_edge(RIGHT_CH, 1'b0, 16'd2000);
		// zero difference becomes a full period and saturates
		add_edge(LEFT_CH, 1'b1, 16'd500);
		add_edge(LEFT_CH, 1'b0, 16'd500);
		// widest timer span
		add_edge(LEFT_CH, 1'b1, 16'd0);
		add_edge(LEFT_CH, 1'b0, 16'hFFFF);
		// wrap past the reload leaves the width negative
		add_edge(RIGHT_CH, 1'b1, 16'd65000);
		add_edge(RIGHT_CH, 1'b0, 16'd1000);
		// channels with no special meaning
		add_edge(3'd1, 1'b1, 16'd7);
		add_edge(3'd1, 1'b0, 16'd2007);
		add_edge(3'd2, 1'b1, 16'h5555);
		add_edge(3'd2, 1'b0, 16'hAAAA);
		add_edge(3'd5, 1'b1, 16'd300);
		add_edge(3'd5, 1'b0, 16'd1800);
		// out of range channels are ignored
		add_edge(3'd6, 1'b1, 16'hFFFF);
		add_edge(3'd7, 1'b0, 16'd0);
		// negative mode width drops back to manual
		add_edge(MODE_CH, 1'b1, 16'hFFFF);
		add_edge(MODE_CH, 1'b0, 16'd0);
		add_edge(LEFT_CH, 1'b0, 16'd1500);
		settle();

		for (phase = 1; phase <= 8; phase++) begin
			case (phase)
				1: configure(16'hFFFF, 16'hFFFF, 16'h0000);
				2: configure(16'd1, 16'd0, 16'hFFFF);
				3: configure(RELOAD_RST, DUTY_SCALE_RST, THRESHOLD_RST);
				default: configure(
					REG_W'($urandom_range(0, 1) ? $urandom_range(1, 65535) :
						$urandom_range(40000, 65535)),
					REG_W'($urandom_range(0, 65535)),
					REG_W'(($urandom_range(0, 3) != 0) ? $urandom_range(1000, 2000) :
						$urandom_range(0, 65535)));
			endcase
			quiet = (phase == 3) || ($urandom_range(0, 3) == 0);
			add_random_edges((phase == 2) ? 100 : 185);
			settle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("** rc_pulse_width_to_motor_duty: PASSED **");
		else
			$display("** rc_pulse_width_to_motor_duty: FAILED **");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("** rc_pulse_width_to_motor_duty: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/rcpw_pkg.sv
hw/rtl/rcpw_fifo.sv
hw/rtl/rcpw_front.sv
hw/rtl/rcpw_back.sv
hw/rtl/rc_pulse_width_to_motor_duty.sv
bench/tb_top.sv
